### sv/dmrle_pkg.sv
// ----------------------------------------------------------------------------
// dmrle_pkg
// Shared widths, codes and constants of the dual-mode RLE image decoder.
// ----------------------------------------------------------------------------
package dmrle_pkg;

  localparam int BYTE_W               = 8;
  localparam int DIM_W                = 12;
  localparam int PROD_W               = 2 * DIM_W;
  localparam int RUN_LEN_W            = 6;
  localparam int CFG_IDX_W            = 2;
  localparam int PIXEL_COUNT_BITS_DEF = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_RUN_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd2;

  // code byte thresholds
  localparam logic [BYTE_W-1:0] DEFAULT_RUN_BASE = 8'd192;
  localparam logic [BYTE_W-1:0] ZERO_RUN_BASE    = 8'd128;

endpackage

### sv/dmrle_cfg.sv
// ----------------------------------------------------------------------------
// dmrle_cfg
// Configuration registers and the registered pixel total of the image.
// ----------------------------------------------------------------------------
module dmrle_cfg #(
  parameter int PIXEL_COUNT_BITS = dmrle_pkg::PIXEL_COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [dmrle_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [dmrle_pkg::DIM_W-1:0]          wr_data,
  output logic                                 zero_run_mode,
  output logic [PIXEL_COUNT_BITS-1:0]          pixel_limit
);
  import dmrle_pkg::*;

  logic                        mode_r, mode_nxt;
  logic [DIM_W-1:0]            width_r, width_nxt;
  logic [DIM_W-1:0]            height_r, height_nxt;
  logic [PIXEL_COUNT_BITS-1:0] limit_r, limit_nxt;
  logic [DIM_W-1:0]            w_eff, h_eff;
  logic [PROD_W-1:0]           prod;

  always_comb begin
    mode_nxt   = mode_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (wr_index)
        CFG_ZERO_RUN_MODE: mode_nxt   = wr_data[0];
        CFG_IMAGE_WIDTH:   width_nxt  = wr_data;
        CFG_IMAGE_HEIGHT:  height_nxt = wr_data;
        default: ;
      endcase
    end
  end

  // a zero dimension counts as one; total saturates to the counter range
  always_comb begin
    w_eff = (width_nxt == '0)  ? DIM_W'(1) : width_nxt;
    h_eff = (height_nxt == '0) ? DIM_W'(1) : height_nxt;
    prod  = PROD_W'(w_eff) * PROD_W'(h_eff);
    if ((prod >> PIXEL_COUNT_BITS) != '0)
      limit_nxt = '1;
    else
      limit_nxt = PIXEL_COUNT_BITS'(prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      limit_r  <= PIXEL_COUNT_BITS'(1);
    end else begin
      mode_r   <= mode_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      limit_r  <= limit_nxt;
    end
  end

  assign zero_run_mode = mode_r;
  assign pixel_limit   = limit_r;

endmodule

### sv/dmrle_core.sv
// ----------------------------------------------------------------------------
// dmrle_core
// Decode state, run clipping against the pixel total, and the result register.
// ----------------------------------------------------------------------------
module dmrle_core #(
  parameter int PIXEL_COUNT_BITS = dmrle_pkg::PIXEL_COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              zero_run_mode,
  input  logic [PIXEL_COUNT_BITS-1:0]       pixel_limit,
  input  logic                              item_valid,
  input  logic [dmrle_pkg::BYTE_W-1:0]      item_byte,
  output logic                              item_take,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dmrle_pkg::BYTE_W-1:0]      out_value,
  output logic [dmrle_pkg::BYTE_W-1:0]      out_count,
  output logic                              out_done
);
  import dmrle_pkg::*;

  logic                        fill_pending_r, fill_pending_nxt;
  logic [RUN_LEN_W-1:0]        pend_len_r, pend_len_nxt;
  logic [BYTE_W-1:0]           lit_rem_r, lit_rem_nxt;
  logic                        finished_r, finished_nxt;
  logic [PIXEL_COUNT_BITS-1:0] emitted_r, emitted_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]           out_value_r, out_count_r;
  logic                        out_done_r;

  logic                        res_valid;
  logic [BYTE_W-1:0]           res_value;
  logic [BYTE_W-1:0]           cnt_raw, cnt;
  logic [PIXEL_COUNT_BITS-1:0] remain, emitted_sum;
  logic                        res_done;
  logic                        out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign item_take = item_valid && out_free;

  always_comb begin
    fill_pending_nxt = fill_pending_r;
    pend_len_nxt     = pend_len_r;
    lit_rem_nxt      = lit_rem_r;
    finished_nxt     = finished_r;
    emitted_nxt      = emitted_r;
    res_valid        = 1'b0;
    res_value        = item_byte;
    cnt_raw          = BYTE_W'(1);

    if (finished_r) begin
      // image complete: bytes are dropped
    end else if (emitted_r >= pixel_limit) begin
      // total shrunk to or below what is already out
      finished_nxt     = 1'b1;
      fill_pending_nxt = 1'b0;
      pend_len_nxt     = '0;
      lit_rem_nxt      = '0;
    end else if (fill_pending_r) begin
      fill_pending_nxt = 1'b0;
      pend_len_nxt     = '0;
      res_valid        = 1'b1;
      cnt_raw          = BYTE_W'(pend_len_r);
    end else if (lit_rem_r != '0) begin
      lit_rem_nxt = lit_rem_r - BYTE_W'(1);
      res_valid   = 1'b1;
    end else if (zero_run_mode) begin
      if (item_byte > ZERO_RUN_BASE) begin
        res_valid = 1'b1;
        res_value = '0;
        cnt_raw   = item_byte - ZERO_RUN_BASE;
      end else begin
        lit_rem_nxt = item_byte;
      end
    end else if (item_byte > DEFAULT_RUN_BASE) begin
      fill_pending_nxt = 1'b1;
      pend_len_nxt     = RUN_LEN_W'(item_byte - DEFAULT_RUN_BASE);
    end else begin
      res_valid = 1'b1;
    end

    // clip the run to the pixels left
    remain      = pixel_limit - emitted_r;
    cnt         = (PIXEL_COUNT_BITS'(cnt_raw) > remain) ? remain[BYTE_W-1:0] : cnt_raw;
    emitted_sum = emitted_r + PIXEL_COUNT_BITS'(cnt);
    res_done    = (emitted_sum == pixel_limit);

    if (res_valid) begin
      emitted_nxt = emitted_sum;
      if (res_done) begin
        finished_nxt     = 1'b1;
        fill_pending_nxt = 1'b0;
        pend_len_nxt     = '0;
        lit_rem_nxt      = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (item_take)
      out_valid_nxt = res_valid;
    else if (out_ready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_pending_r <= 1'b0;
      pend_len_r     <= '0;
      lit_rem_r      <= '0;
      finished_r     <= 1'b0;
      emitted_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (item_take) begin
        fill_pending_r <= fill_pending_nxt;
        pend_len_r     <= pend_len_nxt;
        lit_rem_r      <= lit_rem_nxt;
        finished_r     <= finished_nxt;
        emitted_r      <= emitted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && res_valid) begin
      out_value_r <= res_value;
      out_count_r <= cnt;
      out_done_r  <= res_done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_count = out_count_r;
  assign out_done  = out_done_r;

  // a pending run header and a literal block never overlap
  a_fill_lit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(fill_pending_r && (lit_rem_r != '0)))
    else $error("run header pending while literals remain");

  // once complete, no decode state is left over
  a_finished_clean: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> (!fill_pending_r && (lit_rem_r == '0)))
    else $error("decode state left after image complete");

  // a completing run closes the image
  a_done_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && res_valid && res_done) |=> finished_r)
    else $error("image_done given without finishing");

  // every delivered run has at least one pixel
  a_nonzero_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r != '0))
    else $error("empty run delivered");

  // nothing is produced after completion
  a_no_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (finished_r && item_take) |=> !out_valid_r)
    else $error("result after image complete");

endmodule

### sv/dual_mode_rle_image_decoder_unit.sv
// ----------------------------------------------------------------------------
// dual_mode_rle_image_decoder_unit
// Byte-oriented run-length decoder for an 8-bit indexed image body.
// ----------------------------------------------------------------------------
// Code bytes arrive on the in_ stream, one per transfer. Each byte yields at
// most one run descriptor on the out_ stream: tdata carries pixel_value in
// [7:0] and run_count in [15:8]; tlast marks the run that completes the image.
// Run headers and literal-block headers produce no transfer of their own.
// Mode and image size are set through the cfg_ channel (index 0 mode,
// 1 width, 2 height), which is always ready; write it only while idle.
// Each byte is held in the input register, then decoded into the result register.
// Throughput: one code byte per cycle unless the receiver stalls; the decode
// state update is a single add and compare on the pixel counter between
// input and result registers.
// When the receiver stalls, one result waits in the output register while
// the next byte is decoded into it as soon as it frees; in_tready drops only
// when both registers are occupied.
// Reset (synchronous, rst_n low) clears all decode state and returns to
// default mode with a 1x1 image. After the final pixel all bytes are
// swallowed without result until the next reset.
// ----------------------------------------------------------------------------
module dual_mode_rle_image_decoder_unit #(
  parameter int PIXEL_COUNT_BITS = dmrle_pkg::PIXEL_COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // code_byte
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dmrle_pkg::BYTE_W-1:0]       in_tdata,
  // pixel_value [7:0], run_count [15:8]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [2*dmrle_pkg::BYTE_W-1:0]     out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dmrle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dmrle_pkg::DIM_W-1:0]        cfg_data
);
  import dmrle_pkg::*;

  logic                        in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0]           in_byte_r;
  logic                        item_take;
  logic                        zero_run_mode;
  logic [PIXEL_COUNT_BITS-1:0] pixel_limit;
  logic [BYTE_W-1:0]           out_value, out_count;

  assign cfg_ready = 1'b1;
  assign in_tready = !in_valid_r || item_take;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tready)
      in_valid_nxt = in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      in_valid_r <= 1'b0;
    else
      in_valid_r <= in_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready)
      in_byte_r <= in_tdata;
  end

  dmrle_cfg #(
    .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (cfg_valid && cfg_ready),
    .wr_index     (cfg_index),
    .wr_data      (cfg_data),
    .zero_run_mode(zero_run_mode),
    .pixel_limit  (pixel_limit)
  );

  dmrle_core #(
    .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .zero_run_mode(zero_run_mode),
    .pixel_limit  (pixel_limit),
    .item_valid   (in_valid_r),
    .item_byte    (in_byte_r),
    .item_take    (item_take),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_value    (out_value),
    .out_count    (out_count),
    .out_done     (out_tlast)
  );

  assign out_tdata = {out_count, out_value};

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dual_mode_rle_image_decoder_unit. Code bytes are
// streamed in under several mode and image-size settings and varying
// back-pressure. A behavioural decoder in the scoreboard predicts every run
// descriptor, and each one leaving the block is compared field by field.
// The run ends by completing the image with a clipped run, followed by bytes
// that must be swallowed.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dmrle_pkg::*;

  localparam int          CNT_BITS      = PIXEL_COUNT_BITS_DEF;
  localparam int          DIM_MAX       = 4095;
  localparam int          RANDOM_ITEMS  = 1030;
  localparam int          STALL_LIMIT   = 5000;
  localparam int          SETTLE_CYCLES = 6;
  localparam logic        MODE_DEFAULT  = 1'b0;
  localparam logic        MODE_ZERO_RUN = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_value;
    logic [BYTE_W-1:0] run_count;
    logic              image_done;
  } run_desc_t;

  class rle_scoreboard;
    logic              zero_run_mode;
    logic [DIM_W-1:0]  width_px;
    logic [DIM_W-1:0]  height_px;
    longint unsigned   pixels_out;
    bit                value_due;
    logic [RUN_LEN_W-1:0] run_len_due;
    logic [BYTE_W-1:0] literals_due;
    bit                image_complete;
    run_desc_t         expected_runs[$];
    int                errors;

    function new();
      zero_run_mode  = MODE_DEFAULT;
      width_px       = 1;
      height_px      = 1;
      pixels_out     = 0;
      value_due      = 0;
      run_len_due    = '0;
      literals_due   = '0;
      image_complete = 0;
      errors         = 0;
    endfunction

    function longint unsigned count_mask();
      return (longint'(1) << CNT_BITS) - 1;
    endfunction

    function longint unsigned pixel_total();
      longint unsigned w;
      longint unsigned h;
      w = (width_px == 0) ? 1 : width_px;
      h = (height_px == 0) ? 1 : height_px;
      return (w * h > count_mask()) ? count_mask() : w * h;
    endfunction

    function int outstanding();
      return expected_runs.size();
    endfunction

    function bit mid_item();
      return value_due || (literals_due != 0);
    endfunction

    function void clear_progress();
      image_complete = 1;
      value_due      = 0;
      run_len_due    = '0;
      literals_due   = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        CFG_ZERO_RUN_MODE: zero_run_mode = val[0];
        CFG_IMAGE_WIDTH:   width_px      = val;
        CFG_IMAGE_HEIGHT:  height_px     = val;
        default: ;
      endcase
    endfunction

    function void push_run(logic [BYTE_W-1:0] value, longint unsigned count);
      longint unsigned total;
      run_desc_t       run;
      total = pixel_total();
      // last run of the image is cut to what is left
      if (count > total - pixels_out) count = total - pixels_out;
      pixels_out = (pixels_out + count) & count_mask();
      run.pixel_value = value;
      run.run_count   = count[BYTE_W-1:0];
      run.image_done  = (pixels_out == total);
      if (run.image_done) clear_progress();
      expected_runs.push_back(run);
    endfunction

    function void note_input(logic [BYTE_W-1:0] b);
      if (image_complete) return;
      // size shrunk to or below what is already out: byte swallowed, image closed
      if (pixels_out >= pixel_total()) begin
        clear_progress();
        return;
      end
      if (value_due) begin
        value_due = 0;
        push_run(b, run_len_due);
        run_len_due = '0;
      end else if (literals_due != 0) begin
        literals_due = literals_due - 1'b1;
        push_run(b, 1);
      end else if (zero_run_mode) begin
        if (b > ZERO_RUN_BASE) push_run('0, b - ZERO_RUN_BASE);
        else literals_due = b;
      end else if (b > DEFAULT_RUN_BASE) begin
        value_due   = 1;
        run_len_due = RUN_LEN_W'(b - DEFAULT_RUN_BASE);
      end else begin
        push_run(b, 1);
      end
    endfunction

    task report_mismatch(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [BYTE_W-1:0] value, logic [BYTE_W-1:0] count, logic last);
      run_desc_t want;
      if (expected_runs.size() == 0) begin
        report_mismatch($sformatf("unexpected run value=%0d count=%0d done=%0b",
                                  value, count, last));
        return;
      end
      want = expected_runs.pop_front();
      if (value !== want.pixel_value)
        report_mismatch($sformatf("pixel_value %0d, wanted %0d", value, want.pixel_value));
      if (count !== want.run_count)
        report_mismatch($sformatf("run_count %0d, wanted %0d", count, want.run_count));
      if (last !== want.image_done)
        report_mismatch($sformatf("image_done %0b, wanted %0b", last, want.image_done));
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [2*BYTE_W-1:0]   out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [DIM_W-1:0]      cfg_data   = '0;

  rle_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int random_sent    = 0;

  dual_mode_rle_image_decoder_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[BYTE_W-1:0], out_tdata[2*BYTE_W-1:BYTE_W], out_tlast);
  end

  // watchdog: cycles without any transfer on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("dual_mode_rle_image_decoder_unit test failed");
    $finish;
  end

  task automatic set_idling(int phase_kind);
    case (phase_kind % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
      default: begin send_idle_pct = 9; recv_stall_pct = 9; end
    endcase
  endtask

  // entered and left just after a falling edge; tvalid is left as it is
  task automatic send_code(logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    sb.note_input(b);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // let the pipeline empty, headers included, before touching the registers
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_code(logic mode);
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return BYTE_W'($urandom_range(255));
    if (mode == MODE_DEFAULT)
      return (sel < 65) ? BYTE_W'($urandom_range(255, 193)) : BYTE_W'($urandom_range(192));
    if (sel < 65) return BYTE_W'($urandom_range(255, 129));
    return (sel < 93) ? BYTE_W'($urandom_range(6)) : BYTE_W'($urandom_range(128));
  endfunction

  task automatic random_phase(int quota);
    int n;
    n = 0;
    // stop early if one byte could complete the image
    while (n < quota && random_sent < RANDOM_ITEMS &&
           sb.pixel_total() - sb.pixels_out >= 128) begin
      send_code(pick_code(sb.zero_run_mode));
      n++;
      random_sent++;
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] dir_a[];
    logic [BYTE_W-1:0] dir_b[];
    logic [BYTE_W-1:0] dir_c[];
    int                phase_no;
    longint unsigned   need;
    longint unsigned   w;
    longint unsigned   h;

    dir_a = '{8'h00, 8'hC0, 8'hC1, 8'h55, 8'hFF, 8'hAB, 8'hC3};
    dir_b = '{8'h81, 8'h81, 8'hFF, 8'h00, 8'h02, 8'hC5, 8'h7F, 8'h03, 8'h11};
    dir_c = '{8'hE0, 8'hFF, 8'h81};

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // zero height counts as one; widest image row
    write_reg(CFG_ZERO_RUN_MODE, DIM_W'(MODE_DEFAULT));
    write_reg(CFG_IMAGE_WIDTH, DIM_W'(DIM_MAX));
    write_reg(CFG_IMAGE_HEIGHT, '0);
    foreach (dir_a[i]) send_code(dir_a[i]);
    // run header pending across a mode switch
    drain();
    write_reg(CFG_ZERO_RUN_MODE, DIM_W'(MODE_ZERO_RUN));
    write_reg(CFG_IMAGE_HEIGHT, 12'd1);
    foreach (dir_b[i]) send_code(dir_b[i]);
    // literals pending across a mode switch
    drain();
    write_reg(CFG_ZERO_RUN_MODE, DIM_W'(MODE_DEFAULT));
    foreach (dir_c[i]) send_code(dir_c[i]);
    drain();

    // single-column image
    write_reg(CFG_ZERO_RUN_MODE, DIM_W'($urandom_range(1)));
    write_reg(CFG_IMAGE_WIDTH, 12'd1);
    write_reg(CFG_IMAGE_HEIGHT, DIM_W'(DIM_MAX));
    set_idling(0);
    random_phase($urandom_range(180, 80));
    drain();

    phase_no = 1;
    while (random_sent < RANDOM_ITEMS) begin
      need = sb.pixels_out + 30000;
      case ($urandom_range(3))
        0:       w = DIM_MAX;
        default: w = $urandom_range(DIM_MAX, 1);
      endcase
      if ((need + w - 1) / w > DIM_MAX) w = DIM_MAX;
      h = (need + w - 1) / w;
      if ($urandom_range(3) == 0) h = DIM_MAX;
      else h = $urandom_range(DIM_MAX, h);
      write_reg(CFG_ZERO_RUN_MODE, DIM_W'($urandom_range(1)));
      write_reg(CFG_IMAGE_WIDTH, DIM_W'(w));
      write_reg(CFG_IMAGE_HEIGHT, DIM_W'(h));
      set_idling(phase_no);
      random_phase($urandom_range(180, 80));
      phase_no++;
      drain();
    end

    // finish any half-decoded item, then leave only a few pixels to go
    set_idling(3);
    while (sb.mid_item()) send_code(BYTE_W'($urandom_range(255)));
    drain();
    if (!sb.image_complete) begin
      w = (sb.pixels_out + 1) / DIM_MAX + 1;
      h = (sb.pixels_out + w) / w;
      write_reg(CFG_ZERO_RUN_MODE, DIM_W'(MODE_ZERO_RUN));
      write_reg(CFG_IMAGE_WIDTH, DIM_W'(w));
      write_reg(CFG_IMAGE_HEIGHT, DIM_W'(h));
      // a full zero run overshoots and is clipped on the last pixel
      while (!sb.image_complete) send_code(8'hFF);
    end
    // everything after the image is swallowed
    repeat (12) send_code(BYTE_W'($urandom_range(255)));
    drain();

    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("dual_mode_rle_image_decoder_unit test passed");
    else
      $display("dual_mode_rle_image_decoder_unit test failed");
    $finish;
  end

endmodule

### files.f
sv/dmrle_pkg.sv
sv/dmrle_cfg.sv
sv/dmrle_core.sv
sv/dual_mode_rle_image_decoder_unit.sv
bench/testbench.sv
